/* rtl/core/wsfr_pkg.sv */
// Shared types, codes and the helper function of the WebSocket frame receiver.
package wsfr_pkg;

   typedef enum logic [2:0] {
      PH_HDR0   = 3'd0,
      PH_HDR1   = 3'd1,
      PH_EXTLEN = 3'd2,
      PH_MASK   = 3'd3,
      PH_DATA   = 3'd4,
      PH_CLOSED = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      DISP_DISCARD = 2'd0,
      DISP_TEXT    = 2'd1,
      DISP_PING    = 2'd2,
      DISP_CLOSE   = 2'd3
   } disp_type;

   typedef enum logic [1:0] {
      KIND_TEXT  = 2'd0,
      KIND_PING  = 2'd1,
      KIND_CLOSE = 2'd2
   } kind_type;

   localparam logic [3:0]  OPC_CONT  = 4'h0;
   localparam logic [3:0]  OPC_TEXT  = 4'h1;
   localparam logic [3:0]  OPC_CLOSE = 4'h8;
   localparam logic [3:0]  OPC_PING  = 4'h9;

   localparam logic [6:0]  LEN_CODE_16 = 7'd126;
   localparam logic [6:0]  LEN_CODE_64 = 7'd127;
   localparam logic [63:0] PING_MAX    = 64'd125;

   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd4096;

   // Chooses how the payload of a frame is handled once its header is complete.
   function automatic disp_type frame_disposition(
      input logic [63:0] length,
      input logic [15:0] max_payload,
      input logic [3:0]  opcode,
      input logic        fin
   );
      disp_type disp;
      if (length > {48'd0, max_payload}) begin
         disp = DISP_DISCARD;
      end else if (opcode == OPC_CLOSE) begin
         disp = DISP_CLOSE;
      end else if (opcode == OPC_PING) begin
         disp = (length <= PING_MAX) ? DISP_PING : DISP_DISCARD;
      end else if ((opcode == OPC_TEXT || opcode == OPC_CONT) && fin) begin
         disp = DISP_TEXT;
      end else begin
         disp = DISP_DISCARD;
      end
      return disp;
   endfunction

endpackage

/* rtl/core/wsfr_if.sv */
// Request and response channel interfaces of the WebSocket frame receiver.
interface wsfr_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] byte_in;

   modport source (output valid, output op, output byte_in, input ready);
   modport sink (input valid, input op, input byte_in, output ready);
endinterface

interface wsfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic       has_byte;
   logic [7:0] data_out;
   logic       last;

   modport source (output valid, output kind, output has_byte, output data_out,
                   output last, input ready);
   modport sink (input valid, input kind, input has_byte, input data_out,
                 input last, output ready);
endinterface

/* rtl/core/websocket_frame_receiver_core.sv */
// Top level of the WebSocket frame receiver: header parser, unmasking and result register.
//
// The request channel carries one stream byte per request (op 0) or a restart
// (op 1) that returns the parser to the start of a frame header. The response
// channel carries unmasked text or ping payload bytes, empty-frame markers and
// the close marker. The csr port writes the largest accepted payload length.
//
// A request is taken into an input register and processed from there once the
// result register is free or being emptied; its response, if any, is then held
// in the result register. One request per cycle is sustained while the response
// sink is ready; the only loop is the parser state update.
//
// When the response sink stalls, one more request is taken into the input
// register and then ready drops until the result register drains.
//
// Reset clears the parser, both registers and sets the payload limit to 4096.
// After a close marker, bytes are ignored until a restart request arrives.
module websocket_frame_receiver_core
   import wsfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   wsfr_req_if.sink    req_chan,
   wsfr_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic        in_valid_ff;
   logic        in_op_ff;
   logic [7:0]  in_byte_ff;
   logic        advance;

   logic [15:0] max_ff;

   phase_type   phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opc_ff, opc_in;
   logic        mask_ff, mask_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  idx_ff, idx_in;
   disp_type    disp_ff, disp_in;
   logic        hdr_end;

   logic        emit;
   kind_type    kind_out;
   logic        has_out;
   logic [7:0]  data_out_c;
   logic        last_out;
   logic [7:0]  key_byte;

   logic        rsp_valid_ff;
   kind_type    rsp_kind_ff;
   logic        rsp_has_ff;
   logic [7:0]  rsp_data_ff;
   logic        rsp_last_ff;

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_op_ff   <= req_chan.op;
         in_byte_ff <= req_chan.byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_wr_en) begin
         max_ff <= csr_wr_data;
      end
   end

   // Next parser state.
   always_comb begin
      logic finish_len;
      finish_len = 1'b0;
      hdr_end    = 1'b0;
      phase_in   = phase_ff;
      count_in   = count_ff;
      fin_in     = fin_ff;
      opc_in     = opc_ff;
      mask_in    = mask_ff;
      len_in     = len_ff;
      key_in     = key_ff;
      idx_in     = idx_ff;
      disp_in    = disp_ff;
      if (in_op_ff) begin
         phase_in = PH_HDR0;
         count_in = 4'd0;
         fin_in   = 1'b0;
         opc_in   = 4'd0;
         mask_in  = 1'b0;
         len_in   = 64'd0;
         key_in   = 32'd0;
         idx_in   = 2'd0;
         disp_in  = DISP_DISCARD;
      end else begin
         unique case (phase_ff)
            PH_HDR0: begin
               fin_in   = in_byte_ff[7];
               opc_in   = in_byte_ff[3:0];
               phase_in = PH_HDR1;
            end
            PH_HDR1: begin
               mask_in = in_byte_ff[7];
               if (in_byte_ff[6:0] == LEN_CODE_16) begin
                  phase_in = PH_EXTLEN;
                  count_in = 4'd2;
                  len_in   = 64'd0;
               end else if (in_byte_ff[6:0] == LEN_CODE_64) begin
                  phase_in = PH_EXTLEN;
                  count_in = 4'd8;
                  len_in   = 64'd0;
               end else begin
                  len_in     = {57'd0, in_byte_ff[6:0]};
                  finish_len = 1'b1;
               end
            end
            PH_EXTLEN: begin
               len_in   = {len_ff[55:0], in_byte_ff};
               count_in = count_ff - 4'd1;
               if (count_in == 4'd0) begin
                  finish_len = 1'b1;
               end
            end
            PH_MASK: begin
               key_in   = {key_ff[23:0], in_byte_ff};
               count_in = count_ff - 4'd1;
               if (count_in == 4'd0) begin
                  hdr_end = 1'b1;
               end
            end
            PH_DATA: begin
               idx_in = idx_ff + 2'd1;
               len_in = len_ff - 64'd1;
               if (len_ff == 64'd1) begin
                  phase_in = (disp_ff == DISP_CLOSE) ? PH_CLOSED : PH_HDR0;
               end
            end
            PH_CLOSED: begin
               phase_in = PH_CLOSED;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         if (finish_len) begin
            key_in = 32'd0;
            if (mask_in) begin
               phase_in = PH_MASK;
               count_in = 4'd4;
            end else begin
               hdr_end = 1'b1;
            end
         end
         if (hdr_end) begin
            disp_in = frame_disposition(len_in, max_ff, opc_in, fin_in);
            idx_in  = 2'd0;
            if (len_in != 64'd0) begin
               phase_in = PH_DATA;
            end else if (disp_in == DISP_CLOSE) begin
               phase_in = PH_CLOSED;
            end else begin
               phase_in = PH_HDR0;
            end
         end
      end
   end

   always_comb begin
      case (idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // Response produced by the request in the input register.
   always_comb begin
      emit       = 1'b0;
      kind_out   = KIND_TEXT;
      has_out    = 1'b0;
      data_out_c = 8'd0;
      last_out   = 1'b1;
      if (!in_op_ff) begin
         if (hdr_end && len_in == 64'd0) begin
            unique case (disp_in)
               DISP_TEXT: begin
                  emit     = 1'b1;
                  kind_out = KIND_TEXT;
               end
               DISP_PING: begin
                  emit     = 1'b1;
                  kind_out = KIND_PING;
               end
               DISP_CLOSE: begin
                  emit     = 1'b1;
                  kind_out = KIND_CLOSE;
               end
               default: begin
                  emit = 1'b0;
               end
            endcase
         end else if (phase_ff == PH_DATA) begin
            last_out = (len_ff == 64'd1);
            unique case (disp_ff)
               DISP_TEXT: begin
                  emit       = 1'b1;
                  kind_out   = KIND_TEXT;
                  has_out    = 1'b1;
                  data_out_c = in_byte_ff ^ key_byte;
               end
               DISP_PING: begin
                  emit       = 1'b1;
                  kind_out   = KIND_PING;
                  has_out    = 1'b1;
                  data_out_c = in_byte_ff ^ key_byte;
               end
               DISP_CLOSE: begin
                  emit     = last_out;
                  kind_out = KIND_CLOSE;
               end
               default: begin
                  emit = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
         count_ff <= 4'd0;
         fin_ff   <= 1'b0;
         opc_ff   <= 4'd0;
         mask_ff  <= 1'b0;
         len_ff   <= 64'd0;
         key_ff   <= 32'd0;
         idx_ff   <= 2'd0;
         disp_ff  <= DISP_DISCARD;
      end else if (advance) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         fin_ff   <= fin_in;
         opc_ff   <= opc_in;
         mask_ff  <= mask_in;
         len_ff   <= len_in;
         key_ff   <= key_in;
         idx_ff   <= idx_in;
         disp_ff  <= disp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_kind_ff <= kind_out;
         rsp_has_ff  <= has_out;
         rsp_data_ff <= data_out_c;
         rsp_last_ff <= last_out;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.kind     = rsp_kind_ff;
   assign rsp_chan.has_byte = rsp_has_ff;
   assign rsp_chan.data_out = rsp_data_ff;
   assign rsp_chan.last     = rsp_last_ff;

   // A frame in its payload phase always has bytes left to consume.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> len_ff != 64'd0)
      else $error("payload phase entered with zero remaining length");

   // Nothing but a restart leaves the closed state, and it produces no response.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CLOSED && advance |-> !emit && (in_op_ff || phase_in == PH_CLOSED))
      else $error("response or state change after close without restart");

   // A close marker carries no byte and ends its frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_CLOSE |-> !rsp_has_ff && rsp_last_ff)
      else $error("malformed close response");

   // Markers without a payload byte carry a zero data field and are marked last.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_has_ff |-> rsp_data_ff == 8'd0 && rsp_last_ff)
      else $error("marker response with data or without last");

   // Reset leaves both the input and the result register empty.
   assert property (@(posedge clock)
      reset |=> !in_valid_ff && !rsp_valid_ff)
      else $error("registers not emptied by reset");

endmodule

/* test/tb_top.sv */
// Self-checking testbench of the WebSocket frame receiver core with its own frame predictor.
module tb_top;
   import wsfr_pkg::*;

   typedef struct packed {
      logic       op;
      logic [7:0] data;
   } stream_item_type;

   typedef struct packed {
      kind_type   kind;
      logic       has_byte;
      logic [7:0] data;
      logic       last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      RX_OPEN    = 2'd0,
      RX_COIN    = 2'd1,
      RX_PATTERN = 2'd2,
      RX_SPARSE  = 2'd3
   } rx_mode_type;

   localparam logic       OP_BYTE    = 1'b0;
   localparam logic       OP_RESTART = 1'b1;
   localparam logic [3:0] OPC_BINARY = 4'h2;
   localparam int         FORM_SHORT = 0;
   localparam int         FORM_16    = 1;
   localparam int         FORM_64    = 2;
   localparam int         NO_CUT     = -1;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   wsfr_req_if req_if();
   wsfr_rsp_if rsp_if();

   websocket_frame_receiver_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   stream_item_type pending_req[$];
   rsp_word_type    expected_rsp[$];
   int              stim_count = 0;
   int              reqs_taken = 0;
   logic            fail_seen  = 1'b0;
   logic            req_taken  = 1'b0;
   logic            rsp_hold   = 1'b0;
   int              burst_left = 1;
   int              gap_left   = 0;
   int              stall_span = 0;
   rx_mode_type     stall_mode = RX_OPEN;
   logic [15:0]     stall_bits = 16'hFFFF;

   // Predictor state.
   logic [15:0] payload_limit;
   phase_type   prs_phase;
   logic [3:0]  prs_count;
   logic        prs_fin;
   logic [3:0]  prs_opcode;
   logic        prs_masked;
   logic [63:0] prs_remaining;
   logic [31:0] prs_key;
   logic [1:0]  prs_key_idx;
   disp_type    prs_disp;

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void reset_parser();
      prs_phase     = PH_HDR0;
      prs_count     = 4'd0;
      prs_fin       = 1'b0;
      prs_opcode    = 4'd0;
      prs_masked    = 1'b0;
      prs_remaining = 64'd0;
      prs_key       = 32'd0;
      prs_key_idx   = 2'd0;
      prs_disp      = DISP_DISCARD;
   endfunction

   function automatic void record_result(kind_type k, logic hb, logic [7:0] d, logic l);
      rsp_word_type r;
      r.kind       = k;
      r.has_byte   = hb;
      r.data       = d;
      r.last       = l;
      expected_rsp = {expected_rsp, r};
   endfunction

   function automatic void settle_header();
      if (prs_remaining > {48'd0, payload_limit}) begin
         prs_disp = DISP_DISCARD;
      end else if (prs_opcode == OPC_CLOSE) begin
         prs_disp = DISP_CLOSE;
      end else if (prs_opcode == OPC_PING) begin
         prs_disp = (prs_remaining <= PING_MAX) ? DISP_PING : DISP_DISCARD;
      end else if ((prs_opcode == OPC_TEXT || prs_opcode == OPC_CONT) && prs_fin) begin
         prs_disp = DISP_TEXT;
      end else begin
         prs_disp = DISP_DISCARD;
      end
      prs_key_idx = 2'd0;
      if (prs_remaining != 64'd0) begin
         prs_phase = PH_DATA;
      end else begin
         prs_phase = PH_HDR0;
         case (prs_disp)
            DISP_TEXT: record_result(KIND_TEXT, 1'b0, 8'd0, 1'b1);
            DISP_PING: record_result(KIND_PING, 1'b0, 8'd0, 1'b1);
            DISP_CLOSE: begin
               prs_phase = PH_CLOSED;
               record_result(KIND_CLOSE, 1'b0, 8'd0, 1'b1);
            end
            default: ;
         endcase
      end
   endfunction

   function automatic void end_of_length();
      prs_key = 32'd0;
      if (prs_masked) begin
         prs_phase = PH_MASK;
         prs_count = 4'd4;
      end else begin
         settle_header();
      end
   endfunction

   function automatic void parse_stream_item(logic op, logic [7:0] b);
      logic [7:0] plain;
      logic       fin_byte;
      if (op == OP_RESTART) begin
         reset_parser();
      end else begin
         case (prs_phase)
            PH_HDR0: begin
               prs_fin    = b[7];
               prs_opcode = b[3:0];
               prs_phase  = PH_HDR1;
            end
            PH_HDR1: begin
               prs_masked    = b[7];
               prs_remaining = 64'd0;
               if (b[6:0] == LEN_CODE_16) begin
                  prs_phase = PH_EXTLEN;
                  prs_count = 4'd2;
               end else if (b[6:0] == LEN_CODE_64) begin
                  prs_phase = PH_EXTLEN;
                  prs_count = 4'd8;
               end else begin
                  prs_remaining = {57'd0, b[6:0]};
                  end_of_length();
               end
            end
            PH_EXTLEN: begin
               prs_remaining = {prs_remaining[55:0], b};
               prs_count     = prs_count - 4'd1;
               if (prs_count == 4'd0) end_of_length();
            end
            PH_MASK: begin
               prs_key   = {prs_key[23:0], b};
               prs_count = prs_count - 4'd1;
               if (prs_count == 4'd0) settle_header();
            end
            PH_DATA: begin
               plain         = b ^ prs_key[8 * (3 - prs_key_idx) +: 8];
               prs_key_idx   = prs_key_idx + 2'd1;
               prs_remaining = prs_remaining - 64'd1;
               fin_byte      = (prs_remaining == 64'd0);
               if (fin_byte) prs_phase = PH_HDR0;
               case (prs_disp)
                  DISP_TEXT: record_result(KIND_TEXT, 1'b1, plain, fin_byte);
                  DISP_PING: record_result(KIND_PING, 1'b1, plain, fin_byte);
                  DISP_CLOSE: begin
                     if (fin_byte) begin
                        prs_phase = PH_CLOSED;
                        record_result(KIND_CLOSE, 1'b0, 8'd0, 1'b1);
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   endfunction

   task automatic push_req(input logic op, input logic [7:0] data);
      stream_item_type item;
      item.op     = op;
      item.data   = data;
      pending_req = {pending_req, item};
      stim_count++;
   endtask

   task automatic push_frame(input logic fin, input logic [3:0] opc, input logic [63:0] len,
                             input int form, input logic masked, input int cut);
      logic [2:0] rsv;
      longint     count;
      int         used_form;
      rsv = 3'($urandom_range(0, 7));
      used_form = form;
      if (used_form == FORM_SHORT && len > 64'd125) used_form = FORM_16;
      if (used_form == FORM_16 && len > 64'd65535) used_form = FORM_64;
      push_req(OP_BYTE, {fin, rsv, opc});
      case (used_form)
         FORM_SHORT: push_req(OP_BYTE, {masked, len[6:0]});
         FORM_16: begin
            push_req(OP_BYTE, {masked, LEN_CODE_16});
            push_req(OP_BYTE, len[15:8]);
            push_req(OP_BYTE, len[7:0]);
         end
         default: begin
            push_req(OP_BYTE, {masked, LEN_CODE_64});
            for (int i = 7; i >= 0; i--) push_req(OP_BYTE, len[8 * i +: 8]);
         end
      endcase
      if (masked) begin
         for (int i = 0; i < 4; i++) push_req(OP_BYTE, rand_byte());
      end
      if (cut >= 0 && 64'(cut) < len) count = longint'(cut);
      else count = longint'(len);
      for (longint i = 0; i < count; i++) push_req(OP_BYTE, rand_byte());
      if (cut >= 0) push_req(OP_RESTART, rand_byte());
   endtask

   task automatic push_random_frame();
      int          sel;
      int          pick;
      int          form;
      int          cut;
      logic [63:0] len;
      logic [3:0]  opc;
      logic        fin;
      logic        masked;
      sel = $urandom_range(0, 99);
      if (sel < 35) opc = OPC_TEXT;
      else if (sel < 50) opc = OPC_CONT;
      else if (sel < 70) opc = OPC_PING;
      else if (sel < 76) opc = OPC_CLOSE;
      else if (sel < 82) opc = OPC_BINARY;
      else opc = 4'($urandom_range(0, 15));
      fin    = ($urandom_range(0, 7) != 0);
      masked = ($urandom_range(0, 9) < 7);
      form   = $urandom_range(0, 9);
      form   = (form < 7) ? FORM_SHORT : (form < 9) ? FORM_16 : FORM_64;
      pick   = $urandom_range(0, 99);
      if (pick < 60) begin
         len = 64'($urandom_range(0, 12));
      end else if (pick < 72) begin
         len = 64'($urandom_range(120, 130));
      end else if (pick < 84 && payload_limit <= 16'd300) begin
         len = {48'd0, payload_limit} + 64'($urandom_range(0, 4));
         len = (len >= 64'd2) ? len - 64'd2 : 64'd0;
      end else if (pick < 94) begin
         len = 64'($urandom_range(13, 300));
      end else begin
         len = {$urandom, $urandom};
         if ($urandom_range(0, 1) == 0) len[63] = 1'b1;
         len[31] = 1'b1;
         form = FORM_64;
      end
      if (len > 64'd1000) cut = $urandom_range(0, 6);
      else if ($urandom_range(0, 19) == 0) cut = $urandom_range(0, int'(len));
      else cut = NO_CUT;
      push_frame(fin, opc, len, form, masked, cut);
      if (opc == OPC_CLOSE) begin
         repeat ($urandom_range(0, 3)) push_req(OP_BYTE, rand_byte());
         push_req(OP_RESTART, rand_byte());
      end
   endtask

   task automatic push_random_traffic(input int amount);
      int target;
      target = stim_count + amount;
      while (stim_count < target) begin
         if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 4)) push_req(OP_BYTE, rand_byte());
            push_req(OP_RESTART, rand_byte());
         end else begin
            push_random_frame();
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_req.size() != 0 || req_if.valid || expected_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      payload_limit = value;
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

   // Long receiver hold-off so that the block fills up and stalls its input.
   initial begin
      wait (reqs_taken >= 700);
      @(negedge clock);
      rsp_hold <= 1'b1;
      repeat (300) @(negedge clock);
      rsp_hold <= 1'b0;
   end

   always @(negedge clock) begin
      stream_item_type item;
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.op      <= OP_BYTE;
         req_if.byte_in <= 8'd0;
      end else if (!req_if.valid || req_taken) begin
         if (gap_left != 0 || pending_req.size() == 0) begin
            if (gap_left != 0) gap_left <= gap_left - 1;
            req_if.valid <= 1'b0;
         end else begin
            item = pending_req.pop_front();
            req_if.valid   <= 1'b1;
            req_if.op      <= item.op;
            req_if.byte_in <= item.data;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 32);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   always @(negedge clock) begin
      logic ready_now;
      if (stall_span == 0) begin
         stall_span <= $urandom_range(20, 80);
         stall_mode <= rx_mode_type'($urandom_range(0, 3));
         stall_bits <= 16'($urandom_range(0, 65535));
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         RX_OPEN: ready_now = 1'b1;
         RX_COIN: ready_now = 1'($urandom_range(0, 1));
         RX_PATTERN: ready_now = stall_bits[stall_span[3:0]];
         default: ready_now = ($urandom_range(0, 3) == 0);
      endcase
      rsp_if.ready <= ready_now && !rsp_hold;
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected response: kind %0d has_byte %0d data_out %0h last %0d",
                      rsp_if.kind, rsp_if.has_byte, rsp_if.data_out, rsp_if.last);
               fail_seen = 1'b1;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_if.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_if.kind);
                  fail_seen = 1'b1;
               end
               if (rsp_if.has_byte !== want.has_byte) begin
                  $error("has_byte: expected %0d, got %0d", want.has_byte, rsp_if.has_byte);
                  fail_seen = 1'b1;
               end
               if (rsp_if.data_out !== want.data) begin
                  $error("data_out: expected %0h, got %0h", want.data, rsp_if.data_out);
                  fail_seen = 1'b1;
               end
               if (rsp_if.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_if.last);
                  fail_seen = 1'b1;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            parse_stream_item(req_if.op, req_if.byte_in);
            reqs_taken++;
         end
      end
   end

   initial begin
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = 16'd0;
      payload_limit  = MAX_PAYLOAD_RESET;
      reset_parser();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_req(OP_RESTART, 8'hFF);
      push_frame(1'b1, OPC_TEXT, 64'd0, FORM_SHORT, 1'b0, NO_CUT);
      push_frame(1'b1, OPC_PING, 64'd0, FORM_SHORT, 1'b1, NO_CUT);
      push_frame(1'b1, OPC_TEXT, 64'd5, FORM_16, 1'b1, NO_CUT);
      push_frame(1'b1, OPC_CONT, 64'd2, FORM_64, 1'b0, NO_CUT);
      push_frame(1'b0, OPC_TEXT, 64'd3, FORM_SHORT, 1'b1, NO_CUT);
      push_frame(1'b1, OPC_BINARY, 64'd2, FORM_SHORT, 1'b0, NO_CUT);
      push_frame(1'b1, 4'hF, 64'd1, FORM_SHORT, 1'b1, NO_CUT);
      push_frame(1'b1, OPC_PING, 64'd125, FORM_SHORT, 1'b1, NO_CUT);
      push_frame(1'b1, OPC_PING, 64'd126, FORM_16, 1'b0, NO_CUT);
      push_frame(1'b1, OPC_TEXT, 64'h8000_0000_0000_0003, FORM_64, 1'b1, 3);
      push_frame(1'b1, OPC_CLOSE, 64'd2, FORM_SHORT, 1'b1, NO_CUT);
      push_req(OP_BYTE, 8'h81);
      push_req(OP_BYTE, 8'h00);
      push_req(OP_RESTART, 8'h00);
      push_frame(1'b1, OPC_CLOSE, 64'd0, FORM_SHORT, 1'b0, NO_CUT);
      push_req(OP_RESTART, 8'h5A);
      push_random_traffic(400);
      wait_drained();

      write_limit(16'd0);
      push_frame(1'b1, OPC_TEXT, 64'd1, FORM_SHORT, 1'b1, NO_CUT);
      push_frame(1'b1, OPC_CLOSE, 64'd2, FORM_SHORT, 1'b0, NO_CUT);
      push_frame(1'b1, OPC_TEXT, 64'd0, FORM_SHORT, 1'b1, NO_CUT);
      push_random_traffic(300);
      wait_drained();

      write_limit(16'hFFFF);
      push_random_traffic(400);
      wait_drained();

      write_limit(16'd125);
      push_random_traffic(300);
      wait_drained();

      write_limit(16'd126);
      push_random_traffic(300);
      wait_drained();

      write_limit(16'($urandom_range(1, 200)));
      push_random_traffic(300);
      wait_drained();

      if (!fail_seen) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
